// File: hw/rtl/ohlc_pkg.sv
// Shared types and constants for the one-minute OHLC bar builder.
// No dependencies; imported by tick_to_minute_ohlc_bars, ohlc_bar_update and ohlc_out_queue.
package ohlc_pkg;

   localparam int INSTRUMENTS_DEF = 256;

   localparam int IDX_W   = 8;
   localparam int MIN_W   = 11;
   localparam int SEC_W   = 6;
   localparam int PRICE_W = 32;
   localparam int VOL_W   = 32;
   localparam int TURN_W  = 48;
   localparam int OI_W    = 32;

   // one market tick
   typedef struct packed {
      logic [IDX_W-1:0]   instrument;
      logic [MIN_W-1:0]   minute;
      logic [SEC_W-1:0]   second;
      logic [PRICE_W-1:0] price;
      logic [VOL_W-1:0]   volume;
      logic [TURN_W-1:0]  turnover;
      logic [OI_W-1:0]    interest;
   } req_type;

   // per-instrument bar state, one RAM word
   typedef struct packed {
      logic               valid;
      logic [MIN_W-1:0]   minute;
      logic [PRICE_W-1:0] open_p;
      logic [PRICE_W-1:0] high_p;
      logic [PRICE_W-1:0] low_p;
      logic [PRICE_W-1:0] close_p;
      logic [VOL_W-1:0]   base_volume;
      logic [TURN_W-1:0]  base_turnover;
      logic [VOL_W-1:0]   tick_volume;
      logic [TURN_W-1:0]  tick_turnover;
      logic [OI_W-1:0]    position;
      logic [VOL_W-1:0]   volume;
      logic [TURN_W-1:0]  turnover;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   // one result beat
   typedef struct packed {
      logic               complete;
      logic [IDX_W-1:0]   instrument;
      logic [MIN_W-1:0]   minute;
      logic [SEC_W-1:0]   second;
      logic [PRICE_W-1:0] open_p;
      logic [PRICE_W-1:0] high_p;
      logic [PRICE_W-1:0] low_p;
      logic [PRICE_W-1:0] close_p;
      logic [VOL_W-1:0]   volume;
      logic [TURN_W-1:0]  turnover;
      logic [OI_W-1:0]    position;
      logic               last;
   } bar_type;

endpackage

// File: hw/rtl/tick_to_minute_ohlc_bars.sv
// One-minute OHLC bar builder, one bar per instrument slot.
// Uses ohlc_pkg, ohlc_ram, ohlc_bar_update and ohlc_out_queue.
//
// req channel: one market tick per beat (instrument, minute, second, price,
// cumulative volume and turnover, open interest). rsp channel: bar beats.
// A tick whose minute differs from the slot's stored minute gives two beats,
// the finished bar (complete=1) then the running bar; any other tick gives one
// running-bar beat. last_of_run marks the final beat of a tick. A tick whose
// instrument index is at or above INSTRUMENTS is dropped with no beat.
// The first beat of a tick is written into the result queue from stage 1 once the queue
// has room, and is then presented on rsp from the queue's head register.
// Throughput: one tick per cycle while req_stall is low, set by the rsp port moving one
// beat per cycle, so a minute-change tick can hold the next tick back. The slot state
// lives in one RAM, read when a tick is accepted and written back when its beats
// enter the queue; a back-to-back tick for the same slot takes the written-back state
// from a bypass register.
// Reset: synchronous; afterwards the block sweeps every address of the slot RAM,
// holding req_stall high, to clear every slot's valid mark.
// A stalled rsp holds its beat; the two-entry result queue then fills and
// req_stall rises until room frees up.
module tick_to_minute_ohlc_bars
   import ohlc_pkg::*;
#(
   parameter int INSTRUMENTS = INSTRUMENTS_DEF
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [IDX_W-1:0]   req_instrument_index,
   input  logic [MIN_W-1:0]   req_minute_of_day,
   input  logic [SEC_W-1:0]   req_tick_second,
   input  logic [PRICE_W-1:0] req_last_price,
   input  logic [VOL_W-1:0]   req_cumulative_volume,
   input  logic [TURN_W-1:0]  req_cumulative_turnover,
   input  logic [OI_W-1:0]    req_open_interest,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_bar_complete,
   output logic [IDX_W-1:0]   rsp_bar_instrument,
   output logic [MIN_W-1:0]   rsp_bar_minute,
   output logic [SEC_W-1:0]   rsp_bar_second,
   output logic [PRICE_W-1:0] rsp_open_price,
   output logic [PRICE_W-1:0] rsp_high_price,
   output logic [PRICE_W-1:0] rsp_low_price,
   output logic [PRICE_W-1:0] rsp_close_price,
   output logic [VOL_W-1:0]   rsp_bar_volume,
   output logic [TURN_W-1:0]  rsp_bar_turnover,
   output logic [OI_W-1:0]    rsp_bar_position,
   output logic               rsp_last_of_run
);

   localparam int AddrW = (INSTRUMENTS > 1) ? $clog2(INSTRUMENTS) : 1;

   req_type    req_in;
   logic       accept, in_range;

   req_type    s1_item_ff;
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_inrange_ff;
   logic       s1_hit_ff, s1_hit_in;
   slot_type   fwd_ff;

   logic             clr_active_ff;
   logic [AddrW-1:0] clr_cnt_ff;

   logic [SLOT_W-1:0] rd_data;
   logic              wr_en;
   logic [AddrW-1:0]  wr_addr;
   logic [SLOT_W-1:0] wr_data;

   slot_type   cur, nxt;
   logic       has_done;
   bar_type    done_bar, upd_bar, push0, head;
   logic [1:0] push_n, push_cnt, space;
   logic       commit;

   assign req_in.instrument = req_instrument_index;
   assign req_in.minute     = req_minute_of_day;
   assign req_in.second     = req_tick_second;
   assign req_in.price      = req_last_price;
   assign req_in.volume     = req_cumulative_volume;
   assign req_in.turnover   = req_cumulative_turnover;
   assign req_in.interest   = req_open_interest;

   assign accept   = req_valid && !req_stall;
   assign in_range = 32'(req_instrument_index) < 32'(INSTRUMENTS);

   // stage 1: RAM word arrives, or bypass from the write that raced the read
   assign cur = s1_hit_ff ? fwd_ff : slot_type'(rd_data);

   ohlc_bar_update u_update (
      .item     (s1_item_ff),
      .cur      (cur),
      .nxt      (nxt),
      .has_done (has_done),
      .done_bar (done_bar),
      .upd_bar  (upd_bar)
   );

   assign push_n    = !s1_inrange_ff ? 2'd0 : (has_done ? 2'd2 : 2'd1);
   assign commit    = s1_valid_ff && (push_n <= space);
   assign push_cnt  = commit ? push_n : 2'd0;
   assign push0     = has_done ? done_bar : upd_bar;
   assign req_stall = clr_active_ff || (s1_valid_ff && !commit);

   assign s1_valid_in = accept ? 1'b1 : (commit ? 1'b0 : s1_valid_ff);
   assign s1_hit_in   = accept ? (commit && s1_inrange_ff &&
                                  (s1_item_ff.instrument == req_instrument_index))
                               : (commit ? 1'b0 : s1_hit_ff);

   always_comb begin
      if (clr_active_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
         wr_data = '0;
      end else begin
         wr_en   = commit && s1_inrange_ff;
         wr_addr = AddrW'(s1_item_ff.instrument);
         wr_data = SLOT_W'(nxt);
      end
   end

   ohlc_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (INSTRUMENTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (AddrW'(req_instrument_index)),
      .rd_data (rd_data)
   );

   ohlc_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_cnt),
      .push0     (push0),
      .push1     (upd_bar),
      .space     (space),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .head      (head)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s1_hit_ff     <= 1'b0;
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s1_hit_ff   <= s1_hit_in;
         if (clr_active_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == AddrW'(INSTRUMENTS - 1)) begin
               clr_active_ff <= 1'b0;
            end
         end
      end
      if (accept) begin
         s1_item_ff    <= req_in;
         s1_inrange_ff <= in_range;
      end
      if (commit) begin
         fwd_ff <= nxt;
      end
   end

   assign rsp_bar_complete   = head.complete;
   assign rsp_bar_instrument = head.instrument;
   assign rsp_bar_minute     = head.minute;
   assign rsp_bar_second     = head.second;
   assign rsp_open_price     = head.open_p;
   assign rsp_high_price     = head.high_p;
   assign rsp_low_price      = head.low_p;
   assign rsp_close_price    = head.close_p;
   assign rsp_bar_volume     = head.volume;
   assign rsp_bar_turnover   = head.turnover;
   assign rsp_bar_position   = head.position;
   assign rsp_last_of_run    = head.last;

   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> (!s1_valid_ff && !rsp_valid))
      else $error("tick in flight during slot clear");

   a_bypass_valid: assert property (@(posedge clock) disable iff (reset)
      s1_hit_ff |-> (s1_valid_ff && s1_inrange_ff))
      else $error("bypass selected without an in-range tick");

   a_capture: assert property (@(posedge clock) disable iff (reset)
      accept |=> (s1_valid_ff && (s1_item_ff == $past(req_in))))
      else $error("accepted tick not captured");

endmodule

// File: hw/rtl/ohlc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read-first on a same-address collision. No dependencies.
module ohlc_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/ohlc_bar_update.sv
// Bar update logic: next slot state and the result beats for one tick.
// Depends on ohlc_pkg.
module ohlc_bar_update
   import ohlc_pkg::*;
(
   input  req_type  item,
   input  slot_type cur,
   output slot_type nxt,
   output logic     has_done,
   output bar_type  done_bar,
   output bar_type  upd_bar
);

   logic [VOL_W-1:0]  base_vol;
   logic [TURN_W-1:0] base_turn;
   logic [VOL_W-1:0]  diff_vol;
   logic [TURN_W-1:0] diff_turn;

   assign has_done = cur.valid && (cur.minute != item.minute);

   // new minute rebases on the previous tick's cumulative counters
   assign base_vol  = has_done ? cur.tick_volume   : cur.base_volume;
   assign base_turn = has_done ? cur.tick_turnover : cur.base_turnover;

   // counter went backwards: take the raw value
   assign diff_vol  = (item.volume >= base_vol) ? (item.volume - base_vol) : item.volume;
   assign diff_turn = (item.turnover >= base_turn) ? (item.turnover - base_turn)
                                                   : item.turnover;

   always_comb begin
      nxt = cur;
      priority if (!cur.valid || has_done) begin
         nxt.minute  = item.minute;
         nxt.open_p  = item.price;
         nxt.high_p  = item.price;
         nxt.low_p   = item.price;
         nxt.close_p = item.price;
      end else begin
         if (item.price > cur.high_p) begin
            nxt.high_p = item.price;
         end
         if (item.price < cur.low_p) begin
            nxt.low_p = item.price;
         end
         nxt.close_p = item.price;
      end

      if (!cur.valid) begin
         nxt.base_volume   = item.volume;
         nxt.base_turnover = item.turnover;
         nxt.volume        = item.volume;
         nxt.turnover      = item.turnover;
      end else begin
         nxt.base_volume   = base_vol;
         nxt.base_turnover = base_turn;
         nxt.volume        = diff_vol;
         nxt.turnover      = diff_turn;
      end

      nxt.valid         = 1'b1;
      nxt.tick_volume   = item.volume;
      nxt.tick_turnover = item.turnover;
      nxt.position      = item.interest;
   end

   always_comb begin
      done_bar.complete   = 1'b1;
      done_bar.instrument = item.instrument;
      done_bar.minute     = cur.minute;
      done_bar.second     = '0;
      done_bar.open_p     = cur.open_p;
      done_bar.high_p     = cur.high_p;
      done_bar.low_p      = cur.low_p;
      done_bar.close_p    = cur.close_p;
      done_bar.volume     = cur.volume;
      done_bar.turnover   = cur.turnover;
      done_bar.position   = cur.position;
      done_bar.last       = 1'b0;

      upd_bar.complete    = 1'b0;
      upd_bar.instrument  = item.instrument;
      upd_bar.minute      = nxt.minute;
      upd_bar.second      = item.second;
      upd_bar.open_p      = nxt.open_p;
      upd_bar.high_p      = nxt.high_p;
      upd_bar.low_p       = nxt.low_p;
      upd_bar.close_p     = nxt.close_p;
      upd_bar.volume      = nxt.volume;
      upd_bar.turnover    = nxt.turnover;
      upd_bar.position    = nxt.position;
      upd_bar.last        = 1'b1;
   end

endmodule

// File: hw/rtl/ohlc_out_queue.sv
// Two-entry result queue in front of the rsp channel; takes up to two beats a cycle.
// Depends on ohlc_pkg.
module ohlc_out_queue
   import ohlc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_n,
   input  bar_type    push0,
   input  bar_type    push1,
   output logic [1:0] space,
   output logic       out_valid,
   input  logic       out_stall,
   output bar_type    head
);

   logic [1:0] count_ff, count_in, mid_cnt;
   bar_type    q0_ff, q0_in, q1_ff, q1_in;
   logic       pop;

   assign out_valid = (count_ff != 2'd0);
   assign pop       = out_valid && !out_stall;
   assign space     = 2'd2 - count_ff + {1'b0, pop};
   assign mid_cnt   = count_ff - {1'b0, pop};
   assign count_in  = mid_cnt + push_n;
   assign head      = q0_ff;

   always_comb begin
      q0_in = pop ? q1_ff : q0_ff;
      q1_in = q1_ff;
      unique case (push_n)
         2'd0: begin
         end
         2'd1: begin
            if (mid_cnt == 2'd0) begin
               q0_in = push0;
            end else begin
               q1_in = push0;
            end
         end
         2'd2: begin
            q0_in = push0;
            q1_in = push1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("result queue overfilled");

   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      push_n <= space)
      else $error("push exceeds free queue entries");

endmodule
